/* src/bmf_pkg.sv */
package bmf_pkg;

   // Default structure of the filter.
   localparam int KERNEL_DEFAULT    = 3;
   localparam int MAX_WIDTH_DEFAULT = 1024;

   // Field widths fixed by the stream format.
   localparam int PIXEL_W      = 8;
   localparam int COORD_W      = 10;
   localparam int CFG_W        = 11;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 11'd768;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd512;

   // Per-pixel information that travels down the pipeline with the data.
   typedef struct packed {
      logic               has_result;
      logic               frame_end;
      logic [COORD_W-1:0] center_col;
      logic [COORD_W-1:0] center_row;
   } meta_type;

endpackage

/* src/box_mean_filter_3x3.sv */
// Channel   Direction  Payload
// req_      in         tdata: pixel; tuser: frame_start
// rsp_      out        tdata: mean_value, center_col, center_row; tlast: frame_end
// csr_      in         index: register number; data: register value
//
// One pixel is accepted every cycle unless a stalled result backs up the pipeline; a
// result is registered through line store read, column sum, window sum and reciprocal multiply.
// The rate is set by the single read and write port of each line store row.
// Reset is synchronous and clears counters, window and configuration; the line
// stores are not cleared. A stalled result holds the pipeline only once every
// stage is full, and pixels that produce no result are dropped at the output.
module box_mean_filter_3x3 #(
   parameter int KERNEL    = bmf_pkg::KERNEL_DEFAULT,
   parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bmf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] pixel
   input  logic                               req_tuser,  // [0] frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] mean_value, [17:8] center_col, [27:18] center_row, [31:28] zero
   output logic [bmf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bmf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmf_pkg::CFG_W-1:0]          csr_data
);

   localparam int PW      = bmf_pkg::PIXEL_W;
   localparam int CRD_W   = bmf_pkg::COORD_W;
   localparam int ROW_W   = bmf_pkg::CFG_W;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int CMP_W   = (CW + 1 > ROW_W + 1) ? CW + 1 : ROW_W + 1;
   localparam int KK      = KERNEL * KERNEL;
   localparam int CSUM_W  = $clog2(KERNEL * 255 + 1);
   localparam int SUM_W   = $clog2(KK * 255 + 1);
   localparam int DIV_L   = $clog2(KK);
   localparam int DIV_S   = SUM_W + DIV_L;
   localparam int DIV_M_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + DIV_M_W;
   // Rounded-up reciprocal; exact floor division for every sum below 2**SUM_W.
   localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'(((64'd1 << DIV_S) + 64'(KK) - 64'd1) / 64'(KK));
   localparam int PAD_W   = bmf_pkg::RSP_DATA_W - PW - 2 * CRD_W;

   // Configuration registers.
   logic [ROW_W-1:0] line_width_ff, line_width_in;
   logic [ROW_W-1:0] frame_height_ff, frame_height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bmf_pkg::CSR_LINE_WIDTH:   line_width_in   = csr_data;
            bmf_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= bmf_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= bmf_pkg::FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Pipeline handshake.
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in, rsp_v_ff, rsp_v_in;
   logic out_free, s3_fire, s3_free, s2_fire, s2_free, s1_fire, accept;

   assign out_free   = !rsp_v_ff || rsp_tready;
   assign s3_fire    = s3_v_ff && out_free;
   assign s3_free    = !s3_v_ff || s3_fire;
   assign s2_fire    = s2_v_ff && s3_free;
   assign s2_free    = !s2_v_ff || s2_fire;
   assign s1_fire    = s1_v_ff && s2_free;
   assign req_tready = !s1_v_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   // Position counters and per-pixel decisions at the input.
   logic [CW-1:0]    col_ff, col_in, col0;
   logic [ROW_W-1:0] row_ff, row_in, row0;
   logic [CMP_W-1:0] w_eff, h_eff, col_ext, row_ext, col_next, row_next;
   logic [CMP_W-1:0] ccol_full, crow_full;
   logic             last_col, last_row;
   bmf_pkg::meta_type meta0;

   always_comb begin
      col0 = req_tuser ? '0 : col_ff;
      row0 = req_tuser ? '0 : row_ff;

      if (line_width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(line_width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(line_width_ff);
      end
      h_eff = (frame_height_ff == '0) ? CMP_W'(1) : CMP_W'(frame_height_ff);

      col_ext  = CMP_W'(col0);
      row_ext  = CMP_W'(row0);
      col_next = col_ext + CMP_W'(1);
      row_next = row_ext + CMP_W'(1);
      last_col = col_next >= w_eff;
      last_row = row_next >= h_eff;

      ccol_full = col_ext - CMP_W'(KERNEL - 1) + CMP_W'(KERNEL / 2);
      crow_full = row_ext - CMP_W'(KERNEL - 1) + CMP_W'(KERNEL / 2);

      meta0.has_result = (col_ext >= CMP_W'(KERNEL - 1)) && (row_ext >= CMP_W'(KERNEL - 1));
      meta0.frame_end  = last_col && last_row;
      meta0.center_col = ccol_full[CRD_W-1:0];
      meta0.center_row = crow_full[CRD_W-1:0];

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            // The next column stays below the clamped width, so it fits.
            col_in = col_next[CW-1:0];
            row_in = row0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line store read data and the incoming pixel.
   logic [PW-1:0]     line_mem [KERNEL-1][MAX_WIDTH];
   logic [PW-1:0]     rd_ff [KERNEL-1];
   logic [PW-1:0]     wr_data [KERNEL-1];
   logic [PW-1:0]     s1_px_ff;
   logic [CW-1:0]     s1_col_ff;
   bmf_pkg::meta_type s1_meta_ff;
   logic              bypass;

   always_comb begin
      // Each row moves up one store; the newest row takes the pixel.
      for (int r = 0; r < KERNEL - 2; r++) begin
         wr_data[r] = rd_ff[r + 1];
      end
      wr_data[KERNEL-2] = s1_px_ff;
   end

   // A read of the column being written in the same cycle takes the new data.
   assign bypass = s1_fire && (s1_col_ff == col0);

   always_ff @(posedge clock) begin
      for (int r = 0; r < KERNEL - 1; r++) begin
         if (s1_fire) begin
            line_mem[r][s1_col_ff] <= wr_data[r];
         end
         if (accept) begin
            rd_ff[r] <= bypass ? wr_data[r] : line_mem[r][col0];
         end
      end
      if (accept) begin
         s1_px_ff   <= req_tdata[PW-1:0];
         s1_col_ff  <= col0;
         s1_meta_ff <= meta0;
      end
   end

   // Stage 2: sum of the new window column.
   logic [CSUM_W-1:0] csum;
   logic [CSUM_W-1:0] s2_csum_ff;
   bmf_pkg::meta_type s2_meta_ff;

   always_comb begin
      csum = CSUM_W'(s1_px_ff);
      for (int r = 0; r < KERNEL - 1; r++) begin
         csum = csum + CSUM_W'(rd_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_csum_ff <= csum;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // Stage 3: the window is kept as column sums; shift and add them.
   logic [CSUM_W-1:0] window_ff [KERNEL];
   logic [CSUM_W-1:0] window_in [KERNEL];
   logic [SUM_W-1:0]  wsum;
   logic [SUM_W-1:0]  s3_sum_ff;
   bmf_pkg::meta_type s3_meta_ff;

   always_comb begin
      for (int c = 0; c < KERNEL - 1; c++) begin
         window_in[c] = window_ff[c + 1];
      end
      window_in[KERNEL-1] = s2_csum_ff;
      wsum = '0;
      for (int c = 0; c < KERNEL; c++) begin
         wsum = wsum + SUM_W'(window_in[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < KERNEL; c++) begin
            window_ff[c] <= '0;
         end
      end else if (s2_fire) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         s3_sum_ff  <= wsum;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // Output register: division by the window area through the reciprocal.
   logic [PROD_W-1:0] prod;
   logic [PW-1:0]     rsp_mean_ff;
   bmf_pkg::meta_type rsp_meta_ff;

   assign prod = PROD_W'(s3_sum_ff) * PROD_W'(DIV_M);

   always_ff @(posedge clock) begin
      if (s3_fire) begin
         rsp_mean_ff <= prod[DIV_S +: PW];
         rsp_meta_ff <= s3_meta_ff;
      end
   end

   assign s1_v_in  = accept || (s1_v_ff && !s1_fire);
   assign s2_v_in  = s1_fire || (s2_v_ff && !s2_fire);
   assign s3_v_in  = s2_fire || (s3_v_ff && !s3_fire);
   assign rsp_v_in = s3_fire ? s3_meta_ff.has_result : (rsp_v_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_meta_ff.center_row, rsp_meta_ff.center_col,
                        rsp_mean_ff};
   assign rsp_tlast  = rsp_meta_ff.frame_end;

endmodule
